// ===== rtl/core/utf8_to_cp437_transcoder_unit_defines.svh =====
// assertion macros for the transcoder rtl
`ifndef UTF8_TO_CP437_TRANSCODER_UNIT_DEFINES_SVH
`define UTF8_TO_CP437_TRANSCODER_UNIT_DEFINES_SVH

`ifndef SYNTHESIS
`define U8CP_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("u8cp assertion failed");
`define U8CP_ASSERT_NEVER(lbl, expr) \
    `U8CP_ASSERT(lbl, !(expr))
`else
`define U8CP_ASSERT(lbl, prop)
`define U8CP_ASSERT_NEVER(lbl, expr)
`endif

`endif

// ===== rtl/core/u8cp_pkg.sv =====
// types, codes and the cp437 reverse map for the transcoder
package u8cp_pkg;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       last_byte;
    } byte_beat_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic [1:0] status;
    } char_beat_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_FORBIDDEN = 2'd2;
    localparam logic [1:0] ST_TRUNCATED = 2'd3;

    localparam int unsigned CP_W   = 21;
    localparam int unsigned ADDR_W = 3;
    localparam logic        REG_REPLACEMENT_CHAR = 1'b0;

    localparam logic [7:0] CHAR_BAR = 8'h7C;

    // returns {hit, glyph}
    function automatic logic [8:0] cp437_lookup(input logic [CP_W-1:0] cp);
        logic [8:0] r;
        r = 9'd0;
        case (cp[15:0])
            16'h0000: r = {1'b1, 8'd0};
            16'h00A0: r = {1'b1, 8'd255};
            16'h00A1: r = {1'b1, 8'd173};
            16'h00A2: r = {1'b1, 8'd155};
            16'h00A3: r = {1'b1, 8'd156};
            16'h00A5: r = {1'b1, 8'd157};
            16'h00A7: r = {1'b1, 8'd21};
            16'h00AA: r = {1'b1, 8'd166};
            16'h00AB: r = {1'b1, 8'd174};
            16'h00AC: r = {1'b1, 8'd170};
            16'h00B0: r = {1'b1, 8'd248};
            16'h00B1: r = {1'b1, 8'd241};
            16'h00B2: r = {1'b1, 8'd253};
            16'h00B5: r = {1'b1, 8'd230};
            16'h00B6: r = {1'b1, 8'd20};
            16'h00B7: r = {1'b1, 8'd250};
            16'h00BA: r = {1'b1, 8'd167};
            16'h00BB: r = {1'b1, 8'd175};
            16'h00BC: r = {1'b1, 8'd172};
            16'h00BD: r = {1'b1, 8'd171};
            16'h00BF: r = {1'b1, 8'd168};
            16'h00C4: r = {1'b1, 8'd142};
            16'h00C5: r = {1'b1, 8'd143};
            16'h00C6: r = {1'b1, 8'd146};
            16'h00C7: r = {1'b1, 8'd128};
            16'h00C9: r = {1'b1, 8'd144};
            16'h00D1: r = {1'b1, 8'd165};
            16'h00D6: r = {1'b1, 8'd153};
            16'h00DC: r = {1'b1, 8'd154};
            16'h00DF: r = {1'b1, 8'd225};
            16'h00E0: r = {1'b1, 8'd133};
            16'h00E1: r = {1'b1, 8'd160};
            16'h00E2: r = {1'b1, 8'd131};
            16'h00E4: r = {1'b1, 8'd132};
            16'h00E5: r = {1'b1, 8'd134};
            16'h00E6: r = {1'b1, 8'd145};
            16'h00E7: r = {1'b1, 8'd135};
            16'h00E8: r = {1'b1, 8'd138};
            16'h00E9: r = {1'b1, 8'd130};
            16'h00EA: r = {1'b1, 8'd136};
            16'h00EB: r = {1'b1, 8'd137};
            16'h00EC: r = {1'b1, 8'd141};
            16'h00ED: r = {1'b1, 8'd161};
            16'h00EE: r = {1'b1, 8'd140};
            16'h00EF: r = {1'b1, 8'd139};
            16'h00F1: r = {1'b1, 8'd164};
            16'h00F2: r = {1'b1, 8'd149};
            16'h00F3: r = {1'b1, 8'd162};
            16'h00F4: r = {1'b1, 8'd147};
            16'h00F6: r = {1'b1, 8'd148};
            16'h00F7: r = {1'b1, 8'd246};
            16'h00F9: r = {1'b1, 8'd151};
            16'h00FA: r = {1'b1, 8'd163};
            16'h00FB: r = {1'b1, 8'd150};
            16'h00FC: r = {1'b1, 8'd129};
            16'h00FF: r = {1'b1, 8'd152};
            16'h0192: r = {1'b1, 8'd159};
            16'h0393: r = {1'b1, 8'd226};
            16'h0398: r = {1'b1, 8'd233};
            16'h03A3: r = {1'b1, 8'd228};
            16'h03A6: r = {1'b1, 8'd232};
            16'h03A9: r = {1'b1, 8'd234};
            16'h03B1: r = {1'b1, 8'd224};
            16'h03B4: r = {1'b1, 8'd235};
            16'h03B5: r = {1'b1, 8'd238};
            16'h03C0: r = {1'b1, 8'd227};
            16'h03C3: r = {1'b1, 8'd229};
            16'h03C4: r = {1'b1, 8'd231};
            16'h03C6: r = {1'b1, 8'd237};
            16'h2022: r = {1'b1, 8'd7};
            16'h203C: r = {1'b1, 8'd19};
            16'h207F: r = {1'b1, 8'd252};
            16'h20A7: r = {1'b1, 8'd158};
            16'h2190: r = {1'b1, 8'd27};
            16'h2191: r = {1'b1, 8'd24};
            16'h2192: r = {1'b1, 8'd26};
            16'h2193: r = {1'b1, 8'd25};
            16'h2194: r = {1'b1, 8'd29};
            16'h2195: r = {1'b1, 8'd18};
            16'h21A8: r = {1'b1, 8'd23};
            16'h2219: r = {1'b1, 8'd249};
            16'h221A: r = {1'b1, 8'd251};
            16'h221E: r = {1'b1, 8'd236};
            16'h221F: r = {1'b1, 8'd28};
            16'h2229: r = {1'b1, 8'd239};
            16'h2248: r = {1'b1, 8'd247};
            16'h2261: r = {1'b1, 8'd240};
            16'h2264: r = {1'b1, 8'd243};
            16'h2265: r = {1'b1, 8'd242};
            16'h2310: r = {1'b1, 8'd169};
            16'h2320: r = {1'b1, 8'd244};
            16'h2321: r = {1'b1, 8'd245};
            16'h2500: r = {1'b1, 8'd196};
            16'h2502: r = {1'b1, 8'd179};
            16'h250C: r = {1'b1, 8'd218};
            16'h2510: r = {1'b1, 8'd191};
            16'h2514: r = {1'b1, 8'd192};
            16'h2518: r = {1'b1, 8'd217};
            16'h251C: r = {1'b1, 8'd195};
            16'h2524: r = {1'b1, 8'd180};
            16'h252C: r = {1'b1, 8'd194};
            16'h2534: r = {1'b1, 8'd193};
            16'h253C: r = {1'b1, 8'd197};
            16'h2550: r = {1'b1, 8'd205};
            16'h2551: r = {1'b1, 8'd186};
            16'h2552: r = {1'b1, 8'd213};
            16'h2553: r = {1'b1, 8'd214};
            16'h2554: r = {1'b1, 8'd201};
            16'h2555: r = {1'b1, 8'd184};
            16'h2556: r = {1'b1, 8'd183};
            16'h2557: r = {1'b1, 8'd187};
            16'h2558: r = {1'b1, 8'd212};
            16'h2559: r = {1'b1, 8'd211};
            16'h255A: r = {1'b1, 8'd200};
            16'h255B: r = {1'b1, 8'd190};
            16'h255C: r = {1'b1, 8'd189};
            16'h255D: r = {1'b1, 8'd188};
            16'h255E: r = {1'b1, 8'd198};
            16'h255F: r = {1'b1, 8'd199};
            16'h2560: r = {1'b1, 8'd204};
            16'h2561: r = {1'b1, 8'd181};
            16'h2562: r = {1'b1, 8'd182};
            16'h2563: r = {1'b1, 8'd185};
            16'h2564: r = {1'b1, 8'd209};
            16'h2565: r = {1'b1, 8'd210};
            16'h2566: r = {1'b1, 8'd203};
            16'h2567: r = {1'b1, 8'd207};
            16'h2568: r = {1'b1, 8'd208};
            16'h2569: r = {1'b1, 8'd202};
            16'h256A: r = {1'b1, 8'd216};
            16'h256B: r = {1'b1, 8'd215};
            16'h256C: r = {1'b1, 8'd206};
            16'h2580: r = {1'b1, 8'd223};
            16'h2584: r = {1'b1, 8'd220};
            16'h2588: r = {1'b1, 8'd219};
            16'h258C: r = {1'b1, 8'd221};
            16'h2590: r = {1'b1, 8'd222};
            16'h2591: r = {1'b1, 8'd176};
            16'h2592: r = {1'b1, 8'd177};
            16'h2593: r = {1'b1, 8'd178};
            16'h25A0: r = {1'b1, 8'd254};
            16'h25AC: r = {1'b1, 8'd22};
            16'h25B2: r = {1'b1, 8'd30};
            16'h25BA: r = {1'b1, 8'd16};
            16'h25BC: r = {1'b1, 8'd31};
            16'h25C4: r = {1'b1, 8'd17};
            16'h25CB: r = {1'b1, 8'd9};
            16'h25D8: r = {1'b1, 8'd8};
            16'h25D9: r = {1'b1, 8'd10};
            16'h263A: r = {1'b1, 8'd1};
            16'h263B: r = {1'b1, 8'd2};
            16'h263C: r = {1'b1, 8'd15};
            16'h2640: r = {1'b1, 8'd12};
            16'h2642: r = {1'b1, 8'd11};
            16'h2660: r = {1'b1, 8'd6};
            16'h2663: r = {1'b1, 8'd5};
            16'h2665: r = {1'b1, 8'd3};
            16'h2666: r = {1'b1, 8'd4};
            16'h266A: r = {1'b1, 8'd13};
            16'h266B: r = {1'b1, 8'd14};
            default:  r = 9'd0;
        endcase
        if (cp[CP_W-1:16] != '0)
        begin
            r = 9'd0;
        end
        return r;
    endfunction

endpackage

// ===== rtl/core/u8cp_in_stage.sv =====
// input register holding one utf-8 beat ahead of the decoder
module u8cp_in_stage
    import u8cp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       byte_valid,
    output logic       byte_ready,
    input  byte_beat_t byte_data,
    input  logic       take,
    output logic       held_valid,
    output byte_beat_t held_data
);

    logic       valid_reg;
    logic       valid_next;
    byte_beat_t data_reg;
    logic       load;

    assign byte_ready = !valid_reg || take;
    assign load       = byte_valid && byte_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= byte_data;
        end
    end

    assign held_valid = valid_reg;
    assign held_data  = data_reg;

endmodule

// ===== rtl/core/u8cp_decode.sv =====
// utf-8 sequence state and per-byte decode to a cp437 result
`include "utf8_to_cp437_transcoder_unit_defines.svh"
module u8cp_decode
    import u8cp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       take,
    input  byte_beat_t item,
    input  logic [7:0] replacement_char,
    output logic       res_valid,
    output char_beat_t res
);

    logic [1:0]      pending_reg;
    logic [1:0]      pending_next;
    logic [CP_W-1:0] partial_reg;
    logic [CP_W-1:0] partial_next;
    logic [CP_W-1:0] shifted;
    logic [CP_W-1:0] cp;
    logic [1:0]      pending_dec;
    logic [8:0]      map_hit;
    logic            complete;
    logic            bad;
    logic [7:0]      b;

    assign b           = item.byte_in;
    assign shifted     = {partial_reg[CP_W-7:0], b[5:0]};
    assign pending_dec = pending_reg - 2'd1;

    always_comb
    begin
        pending_next = pending_reg;
        partial_next = partial_reg;
        complete     = 1'b0;
        bad          = 1'b0;
        cp           = '0;
        res_valid    = 1'b0;
        res.out_char = 8'd0;
        res.status   = ST_OK;

        if (pending_reg == 2'd0)
        begin
            if (!b[7])
            begin
                cp       = {{(CP_W-8){1'b0}}, b};
                complete = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                pending_next = 2'd1;
                partial_next = {{(CP_W-5){1'b0}}, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                pending_next = 2'd2;
                partial_next = {{(CP_W-4){1'b0}}, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                pending_next = 2'd3;
                partial_next = {{(CP_W-3){1'b0}}, b[2:0]};
            end
            else
            begin
                bad = 1'b1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            bad = 1'b1;
        end
        else
        begin
            pending_next = pending_dec;
            partial_next = shifted;
            if (pending_dec == 2'd0)
            begin
                cp           = shifted;
                partial_next = '0;
                complete     = 1'b1;
            end
        end

        map_hit = cp437_lookup(cp);

        if (bad)
        begin
            pending_next = 2'd0;
            partial_next = '0;
            res_valid    = 1'b1;
            res.status   = ST_INVALID;
        end
        else if (!complete)
        begin
            if (item.last_byte)
            begin
                pending_next = 2'd0;
                partial_next = '0;
                res_valid    = 1'b1;
                res.status   = ST_TRUNCATED;
            end
        end
        else if (cp == 21'h00FFFF || cp == 21'h00FFFE)
        begin
            pending_next = 2'd0;
            partial_next = '0;
            res_valid    = 1'b1;
            res.status   = ST_FORBIDDEN;
        end
        else if (cp < 21'h80)
        begin
            res_valid    = 1'b1;
            res.out_char = cp[7:0];
        end
        else if (cp == 21'h0000A6)
        begin
            res_valid    = 1'b1;
            res.out_char = CHAR_BAR;
        end
        else if (map_hit[8])
        begin
            res_valid    = 1'b1;
            res.out_char = map_hit[7:0];
        end
        else if (replacement_char != 8'd0)
        begin
            // zero replacement strips the character
            res_valid    = 1'b1;
            res.out_char = replacement_char;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
        end
        else if (take)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
        end
    end

    `U8CP_ASSERT(a_idle_no_partial, (pending_reg == 2'd0) |-> (partial_reg == '0))
    `U8CP_ASSERT(a_last_due_narrow, (pending_reg == 2'd1) |-> (partial_reg[CP_W-1:15] == '0))
    `U8CP_ASSERT(a_error_clears, (take && res_valid && (res.status != ST_OK)) |=> (pending_reg == 2'd0))
    `U8CP_ASSERT_NEVER(a_error_char_zero, res_valid && (res.status != ST_OK) && (res.out_char != 8'd0))

endmodule

// ===== rtl/core/u8cp_out_stage.sv =====
// result register toward the cp437 output channel
module u8cp_out_stage
    import u8cp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       held_valid,
    input  logic       res_valid,
    input  char_beat_t res,
    output logic       take,
    output logic       char_valid,
    input  logic       char_ready,
    output char_beat_t char_data
);

    logic       valid_reg;
    logic       valid_next;
    char_beat_t data_reg;

    // the decoder may run whenever this register is empty or draining
    assign take = held_valid && (!valid_reg || char_ready);

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = res_valid;
        end
        else if (char_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && res_valid)
        begin
            data_reg <= res;
        end
    end

    assign char_valid = valid_reg;
    assign char_data  = data_reg;

endmodule

// ===== rtl/core/utf8_to_cp437_transcoder_unit.sv =====
// top level: utf-8 byte stream in, cp437 characters out, apb register port
// a byte passes the input register, one decode pass and then the result register
// throughput: one byte per cycle while the output is not stalled
// a stalled output holds one result while the input register still takes a byte
// reset clears the sequence state, both stage valids and replacement_char to zero
module utf8_to_cp437_transcoder_unit
    import u8cp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_ready,
    input  byte_beat_t        byte_data,
    output logic              char_valid,
    input  logic              char_ready,
    output char_beat_t        char_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic       replacement_sel;
    logic [7:0] replacement_char_reg;
    logic [7:0] replacement_char_next;
    logic       cfg_write;
    logic       take;
    logic       held_valid;
    byte_beat_t held_data;
    logic       res_valid;
    char_beat_t res;

    assign pready          = 1'b1;
    assign replacement_sel = (paddr[ADDR_W-1] == REG_REPLACEMENT_CHAR);
    assign cfg_write       = psel && penable && pwrite && pready && replacement_sel;

    always_comb
    begin
        replacement_char_next = replacement_char_reg;
        if (cfg_write)
        begin
            replacement_char_next = pwdata[7:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            replacement_char_reg <= 8'd0;
        end
        else
        begin
            replacement_char_reg <= replacement_char_next;
        end
    end

    assign prdata = replacement_sel ? {24'd0, replacement_char_reg} : 32'd0;

    u8cp_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .take       (take),
        .held_valid (held_valid),
        .held_data  (held_data)
    );

    u8cp_decode u_decode (
        .clk              (clk),
        .rst_n            (rst_n),
        .take             (take),
        .item             (held_data),
        .replacement_char (replacement_char_reg),
        .res_valid        (res_valid),
        .res              (res)
    );

    u8cp_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .held_valid (held_valid),
        .res_valid  (res_valid),
        .res        (res),
        .take       (take),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data)
    );

endmodule

// ===== dv/transcode_checker.sv =====
// checker: predicts cp437 beats from accepted utf-8 bytes and compares them with the output
module transcode_checker
    import u8cp_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    input  logic              byte_ready,
    input  byte_beat_t        byte_data,
    input  logic              char_valid,
    input  logic              char_ready,
    input  char_beat_t        char_data,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatches,
    output int                outstanding,
    output int                chars_checked,
    output int                error_beats,
    output int                stripped_chars
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CP_BITS = 21;
    localparam int MAP_LEN = 160;
    localparam logic [7:0]         BAR_GLYPH = 8'h7C;
    localparam logic [CP_BITS-1:0] CP_NONCHAR_LO = 21'h00FFFE;
    localparam logic [CP_BITS-1:0] CP_NONCHAR_HI = 21'h00FFFF;
    localparam logic [CP_BITS-1:0] CP_ASCII_END = 21'h000080;
    localparam logic [CP_BITS-1:0] CP_BROKEN_BAR = 21'h0000A6;

    // unicode code point and cp437 glyph, one 24-bit entry each
    localparam logic [MAP_LEN*24-1:0] GLYPH_MAP = {
        {16'h0000, 8'd0},   {16'h00A0, 8'd255}, {16'h00A1, 8'd173}, {16'h00A2, 8'd155},
        {16'h00A3, 8'd156}, {16'h00A5, 8'd157}, {16'h00A7, 8'd21},  {16'h00AA, 8'd166},
        {16'h00AB, 8'd174}, {16'h00AC, 8'd170}, {16'h00B0, 8'd248}, {16'h00B1, 8'd241},
        {16'h00B2, 8'd253}, {16'h00B5, 8'd230}, {16'h00B6, 8'd20},  {16'h00B7, 8'd250},
        {16'h00BA, 8'd167}, {16'h00BB, 8'd175}, {16'h00BC, 8'd172}, {16'h00BD, 8'd171},
        {16'h00BF, 8'd168}, {16'h00C4, 8'd142}, {16'h00C5, 8'd143}, {16'h00C6, 8'd146},
        {16'h00C7, 8'd128}, {16'h00C9, 8'd144}, {16'h00D1, 8'd165}, {16'h00D6, 8'd153},
        {16'h00DC, 8'd154}, {16'h00DF, 8'd225}, {16'h00E0, 8'd133}, {16'h00E1, 8'd160},
        {16'h00E2, 8'd131}, {16'h00E4, 8'd132}, {16'h00E5, 8'd134}, {16'h00E6, 8'd145},
        {16'h00E7, 8'd135}, {16'h00E8, 8'd138}, {16'h00E9, 8'd130}, {16'h00EA, 8'd136},
        {16'h00EB, 8'd137}, {16'h00EC, 8'd141}, {16'h00ED, 8'd161}, {16'h00EE, 8'd140},
        {16'h00EF, 8'd139}, {16'h00F1, 8'd164}, {16'h00F2, 8'd149}, {16'h00F3, 8'd162},
        {16'h00F4, 8'd147}, {16'h00F6, 8'd148}, {16'h00F7, 8'd246}, {16'h00F9, 8'd151},
        {16'h00FA, 8'd163}, {16'h00FB, 8'd150}, {16'h00FC, 8'd129}, {16'h00FF, 8'd152},
        {16'h0192, 8'd159}, {16'h0393, 8'd226}, {16'h0398, 8'd233}, {16'h03A3, 8'd228},
        {16'h03A6, 8'd232}, {16'h03A9, 8'd234}, {16'h03B1, 8'd224}, {16'h03B4, 8'd235},
        {16'h03B5, 8'd238}, {16'h03C0, 8'd227}, {16'h03C3, 8'd229}, {16'h03C4, 8'd231},
        {16'h03C6, 8'd237}, {16'h2022, 8'd7},   {16'h203C, 8'd19},  {16'h207F, 8'd252},
        {16'h20A7, 8'd158}, {16'h2190, 8'd27},  {16'h2191, 8'd24},  {16'h2192, 8'd26},
        {16'h2193, 8'd25},  {16'h2194, 8'd29},  {16'h2195, 8'd18},  {16'h21A8, 8'd23},
        {16'h2219, 8'd249}, {16'h221A, 8'd251}, {16'h221E, 8'd236}, {16'h221F, 8'd28},
        {16'h2229, 8'd239}, {16'h2248, 8'd247}, {16'h2261, 8'd240}, {16'h2264, 8'd243},
        {16'h2265, 8'd242}, {16'h2310, 8'd169}, {16'h2320, 8'd244}, {16'h2321, 8'd245},
        {16'h2500, 8'd196}, {16'h2502, 8'd179}, {16'h250C, 8'd218}, {16'h2510, 8'd191},
        {16'h2514, 8'd192}, {16'h2518, 8'd217}, {16'h251C, 8'd195}, {16'h2524, 8'd180},
        {16'h252C, 8'd194}, {16'h2534, 8'd193}, {16'h253C, 8'd197}, {16'h2550, 8'd205},
        {16'h2551, 8'd186}, {16'h2552, 8'd213}, {16'h2553, 8'd214}, {16'h2554, 8'd201},
        {16'h2555, 8'd184}, {16'h2556, 8'd183}, {16'h2557, 8'd187}, {16'h2558, 8'd212},
        {16'h2559, 8'd211}, {16'h255A, 8'd200}, {16'h255B, 8'd190}, {16'h255C, 8'd189},
        {16'h255D, 8'd188}, {16'h255E, 8'd198}, {16'h255F, 8'd199}, {16'h2560, 8'd204},
        {16'h2561, 8'd181}, {16'h2562, 8'd182}, {16'h2563, 8'd185}, {16'h2564, 8'd209},
        {16'h2565, 8'd210}, {16'h2566, 8'd203}, {16'h2567, 8'd207}, {16'h2568, 8'd208},
        {16'h2569, 8'd202}, {16'h256A, 8'd216}, {16'h256B, 8'd215}, {16'h256C, 8'd206},
        {16'h2580, 8'd223}, {16'h2584, 8'd220}, {16'h2588, 8'd219}, {16'h258C, 8'd221},
        {16'h2590, 8'd222}, {16'h2591, 8'd176}, {16'h2592, 8'd177}, {16'h2593, 8'd178},
        {16'h25A0, 8'd254}, {16'h25AC, 8'd22},  {16'h25B2, 8'd30},  {16'h25BA, 8'd16},
        {16'h25BC, 8'd31},  {16'h25C4, 8'd17},  {16'h25CB, 8'd9},   {16'h25D8, 8'd8},
        {16'h25D9, 8'd10},  {16'h263A, 8'd1},   {16'h263B, 8'd2},   {16'h263C, 8'd15},
        {16'h2640, 8'd12},  {16'h2642, 8'd11},  {16'h2660, 8'd6},   {16'h2663, 8'd5},
        {16'h2665, 8'd3},   {16'h2666, 8'd4},   {16'h266A, 8'd13},  {16'h266B, 8'd14}
    };

    logic [1:0]         seq_left;
    logic [CP_BITS-1:0] cp_acc;
    logic [7:0]         repl_char;
    char_beat_t         expected_chars[$];
    char_beat_t         want;
    char_beat_t         res;
    bit                 produced;

    function automatic bit find_glyph(input logic [CP_BITS-1:0] cp, output logic [7:0] glyph);
        logic [23:0] entry;
        bit          hit;
        hit = 1'b0;
        glyph = 8'd0;
        for (int i = 0; i < MAP_LEN; i++)
        begin
            entry = GLYPH_MAP[i*24 +: 24];
            if (cp == {5'd0, entry[23:8]})
            begin
                hit = 1'b1;
                glyph = entry[7:0];
            end
        end
        return hit;
    endfunction

    // advances the sequence state by one byte and gives the beat it causes, if any
    task automatic decode_byte(input byte_beat_t beat, output bit made, output char_beat_t r);
        logic [7:0]         b;
        logic [CP_BITS-1:0] cp;
        logic [7:0]         glyph;
        bit                 complete;
        bit                 bad;
        b = beat.byte_in;
        cp = '0;
        complete = 1'b0;
        bad = 1'b0;
        made = 1'b0;
        r.out_char = 8'd0;
        r.status = ST_OK;
        if (seq_left == 2'd0)
        begin
            if (!b[7])
            begin
                cp = {13'd0, b};
                complete = 1'b1;
            end
            else if (b[7:5] == 3'b110)
            begin
                seq_left = 2'd1;
                cp_acc = {16'd0, b[4:0]};
            end
            else if (b[7:4] == 4'b1110)
            begin
                seq_left = 2'd2;
                cp_acc = {17'd0, b[3:0]};
            end
            else if (b[7:3] == 5'b11110)
            begin
                seq_left = 2'd3;
                cp_acc = {18'd0, b[2:0]};
            end
            else
            begin
                bad = 1'b1;
            end
        end
        else if (b[7:6] != 2'b10)
        begin
            bad = 1'b1;
        end
        else
        begin
            cp_acc = {cp_acc[CP_BITS-7:0], b[5:0]};
            seq_left = seq_left - 2'd1;
            if (seq_left == 2'd0)
            begin
                cp = cp_acc;
                cp_acc = '0;
                complete = 1'b1;
            end
        end

        if (bad)
        begin
            seq_left = 2'd0;
            cp_acc = '0;
            made = 1'b1;
            r.status = ST_INVALID;
        end
        else if (!complete)
        begin
            // a lead or middle byte flagged as the end of the string
            if (beat.last_byte)
            begin
                seq_left = 2'd0;
                cp_acc = '0;
                made = 1'b1;
                r.status = ST_TRUNCATED;
            end
        end
        else if (cp == CP_NONCHAR_LO || cp == CP_NONCHAR_HI)
        begin
            made = 1'b1;
            r.status = ST_FORBIDDEN;
        end
        else if (cp < CP_ASCII_END)
        begin
            made = 1'b1;
            r.out_char = cp[7:0];
        end
        else if (cp == CP_BROKEN_BAR)
        begin
            made = 1'b1;
            r.out_char = BAR_GLYPH;
        end
        else if (find_glyph(cp, glyph))
        begin
            made = 1'b1;
            r.out_char = glyph;
        end
        else if (repl_char != 8'd0)
        begin
            made = 1'b1;
            r.out_char = repl_char;
        end
        else
        begin
            stripped_chars++;
        end
    endtask

    task automatic flag_mismatch(input string what);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] mismatch: %s", $time, what);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_left = 2'd0;
            cp_acc = '0;
            repl_char = 8'd0;
            expected_chars.delete();
            mismatches = 0;
            outstanding = 0;
            chars_checked = 0;
            error_beats = 0;
            stripped_chars = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && (paddr >> 2) == REG_REPLACEMENT_CHAR)
                repl_char = pwdata[7:0];

            // results pass through the input and result registers after their byte, so check before predicting
            if (char_valid && char_ready)
            begin
                chars_checked++;
                if (char_data.status != ST_OK)
                    error_beats++;
                if (expected_chars.size() == 0)
                begin
                    flag_mismatch($sformatf("unexpected beat char=%02h status=%0d",
                                            char_data.out_char, char_data.status));
                end
                else
                begin
                    want = expected_chars.pop_front();
                    if (char_data.out_char !== want.out_char || char_data.status !== want.status)
                        flag_mismatch($sformatf("expected char=%02h status=%0d, got char=%02h status=%0d",
                                                want.out_char, want.status,
                                                char_data.out_char, char_data.status));
                end
            end

            if (byte_valid && byte_ready)
            begin
                decode_byte(byte_data, produced, res);
                if (produced)
                    expected_chars.push_back(res);
            end
            outstanding = expected_chars.size();
        end
    end

endmodule

// ===== dv/testbench.sv =====
// testbench top: utf-8 byte stimulus, char receiver, apb writes and the verdict
module testbench;
    import u8cp_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int REG_SPARE = 1;          // unused index, writes must be ignored
    localparam int PHASE_BYTES = 340;
    localparam int HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES = 8;
    localparam int TIMEOUT_NS = 2_000_000;

    logic              clk;
    logic              rst_n;
    logic              byte_valid;
    logic              byte_ready;
    byte_beat_t        byte_data;
    logic              char_valid;
    logic              char_ready;
    char_beat_t        char_data;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    int mismatches;
    int outstanding;
    int chars_checked;
    int error_beats;
    int stripped_chars;

    int bytes_sent;
    int repl_writes;
    bit sender_idle;
    bit receiver_idle;
    int stall_requests;

    utf8_to_cp437_transcoder_unit u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_ready (byte_ready),
        .byte_data  (byte_data),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    transcode_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .byte_valid     (byte_valid),
        .byte_ready     (byte_ready),
        .byte_data      (byte_data),
        .char_valid     (char_valid),
        .char_ready     (char_ready),
        .char_data      (char_data),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatches     (mismatches),
        .outstanding    (outstanding),
        .chars_checked  (chars_checked),
        .error_beats    (error_beats),
        .stripped_chars (stripped_chars)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #(TIMEOUT_NS);
        $display("timeout with %0d beats outstanding", outstanding);
        $display("FAILURE");
        $finish;
    end

    // receiver: random backpressure plus a long hold-off on request
    initial
    begin
        int hold_left;
        int served;
        hold_left = 0;
        served = 0;
        char_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_requests != served)
            begin
                served = stall_requests;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                char_ready <= 1'b0;
            end
            else if (receiver_idle)
                char_ready <= ($urandom_range(99) >= 32);
            else
                char_ready <= 1'b1;
        end
    end

    task automatic push_byte(input logic [7:0] value, input logic is_last);
        byte_beat_t beat;
        beat.byte_in = value;
        beat.last_byte = is_last;
        while (sender_idle && $urandom_range(99) < 32)
        begin
            @(negedge clk);
            byte_valid <= 1'b0;
        end
        @(negedge clk);
        byte_valid <= 1'b1;
        byte_data <= beat;
        @(posedge clk);
        while (!byte_ready)
            @(posedge clk);
        bytes_sent++;
    endtask

    // utf-8 encoding of cp, last flag only on the final byte
    task automatic send_codepoint(input logic [20:0] cp, input logic is_last);
        if (cp < 21'h80)
        begin
            push_byte(cp[7:0], is_last);
        end
        else if (cp < 21'h800)
        begin
            push_byte({3'b110, cp[10:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, is_last);
        end
        else if (cp < 21'h10000)
        begin
            push_byte({4'b1110, cp[15:12]}, 1'b0);
            push_byte({2'b10, cp[11:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, is_last);
        end
        else
        begin
            push_byte({5'b11110, cp[20:18]}, 1'b0);
            push_byte({2'b10, cp[17:12]}, 1'b0);
            push_byte({2'b10, cp[11:6]}, 1'b0);
            push_byte({2'b10, cp[5:0]}, is_last);
        end
    endtask

    function automatic logic [7:0] lead_for(input int len);
        if (len == 2)
            return {3'b110, 5'($urandom)};
        else if (len == 3)
            return {4'b1110, 4'($urandom)};
        return {5'b11110, 3'($urandom)};
    endfunction

    // lead plus continuations; cut short when keep < len - 1
    task automatic send_raw_seq(input int len, input int keep, input logic is_last);
        push_byte(lead_for(len), is_last && keep == 0);
        for (int i = 1; i <= keep; i++)
            push_byte({2'b10, 6'($urandom)}, is_last && i == keep);
    endtask

    function automatic logic [20:0] pick_mapped_cp();
        case ($urandom_range(3))
            0: return 21'h00A0 + 21'($urandom_range(95));
            1: return 21'h0390 + 21'($urandom_range(63));
            2: return 21'h2190 + 21'($urandom_range(223));
            default: return 21'h2500 + 21'($urandom_range(175));
        endcase
    endfunction

    task automatic send_random_unit();
        int   kind;
        int   len;
        logic tail_last;
        kind = $urandom_range(99);
        tail_last = ($urandom_range(9) == 0);
        len = $urandom_range(2, 4);
        if (kind < 30)
            push_byte(8'($urandom_range(127)), tail_last);
        else if (kind < 55)
            send_codepoint(pick_mapped_cp(), tail_last);
        else if (kind < 60)
            send_codepoint(21'h00FFFE | 21'($urandom_range(1)), tail_last);
        else if (kind < 82)
            send_raw_seq(len, len - 1, tail_last);
        else if (kind < 92)
            send_raw_seq(len, $urandom_range(len - 2), $urandom_range(99) < 70);
        else
            push_byte(8'($urandom), 1'($urandom));
    endtask

    task automatic write_reg(input int idx, input logic [7:0] value);
        @(negedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= ADDR_W'(4 * idx);
        pwdata <= {24'($urandom), value};
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx == int'(REG_REPLACEMENT_CHAR))
            repl_writes++;
    endtask

    // stop sending and let every expected beat arrive, then let the pipe settle
    task automatic wait_idle();
        @(negedge clk);
        byte_valid <= 1'b0;
        while (outstanding != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int  phase_end;
        int  phase_mid;
        bit  mid_done;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_data = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        bytes_sent = 0;
        repl_writes = 0;
        stall_requests = 0;
        sender_idle = 1'b1;
        receiver_idle = 1'b1;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: replacement is zero after reset, so unmapped code points are stripped
        send_codepoint(21'h000000, 1'b0);
        send_codepoint(21'h00007F, 1'b1);
        send_codepoint(21'h0000A6, 1'b0);
        send_codepoint(21'h00256C, 1'b0);
        send_codepoint(21'h0000C0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hC3, 1'b0);
        push_byte(8'h41, 1'b0);
        send_codepoint(21'h00FFFF, 1'b0);
        send_codepoint(21'h00FFFE, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h95, 1'b1);
        send_codepoint(21'h1FFFFF, 1'b0);

        for (int ph = 0; ph < 5; ph++)
        begin
            wait_idle();
            case (ph)
                0: write_reg(REG_SPARE, 8'hA5);
                1: write_reg(int'(REG_REPLACEMENT_CHAR), 8'hFF);
                2: write_reg(int'(REG_REPLACEMENT_CHAR), 8'h01);
                3: write_reg(int'(REG_REPLACEMENT_CHAR), 8'($urandom_range(2, 254)));
                default: write_reg(int'(REG_REPLACEMENT_CHAR), 8'h00);
            endcase
            // no idling on either side during the third phase
            sender_idle = (ph != 2);
            receiver_idle = (ph != 2);
            phase_end = bytes_sent + PHASE_BYTES;
            phase_mid = bytes_sent + PHASE_BYTES / 2;
            mid_done = 1'b0;
            while (bytes_sent < phase_end)
            begin
                if (!mid_done && bytes_sent >= phase_mid)
                begin
                    mid_done = 1'b1;
                    if (ph == 1)
                    begin
                        // receiver holds off while plain ascii keeps coming, filling the pipe
                        stall_requests++;
                        repeat (24) push_byte(8'($urandom_range(127)), 1'b0);
                    end
                    else if (ph == 3)
                        wait_idle();
                end
                send_random_unit();
            end
        end

        wait_idle();
        $display("covered %0d bytes, %0d cp437 beats checked, %0d replacement writes",
                 bytes_sent, chars_checked, repl_writes);
        $display("error beats %0d, stripped characters %0d, receiver hold-off and mid-run drain",
                 error_beats, stripped_chars);
        if (mismatches == 0 && outstanding == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ===== utf8_to_cp437_transcoder_unit.f =====
+incdir+rtl/core
rtl/core/u8cp_pkg.sv
rtl/core/u8cp_in_stage.sv
rtl/core/u8cp_decode.sv
rtl/core/u8cp_out_stage.sv
rtl/core/utf8_to_cp437_transcoder_unit.sv
dv/transcode_checker.sv
dv/testbench.sv
